[design/double_ended_queue_unit_assert.svh]
// assertion macros for the double-ended queue unit
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define DQU_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("deque unit assertion failed");
`define DQU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque unit assertion failed");
`else
`define DQU_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define DQU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[design/dqu_pkg.sv]
// types and constants shared by the double-ended queue unit
package dqu_pkg;

  localparam int OPCODE_W = 3;
  localparam int ITEM_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_PEEK_BACK  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_PEEK_FRONT = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_IN_FRONT,
    CELL_SHIFT_OUT_FRONT,
    CELL_FILL_BACK,
    CELL_DROP_BACK
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

endpackage

[design/dqu_if.sv]
// request and result channel interfaces of the double-ended queue unit
interface dqu_in_if;
  logic                          valid;
  logic                          ready;
  logic [dqu_pkg::OPCODE_W-1:0]  opcode;
  logic [dqu_pkg::ITEM_W-1:0]    item_value;

  modport source (output valid, output opcode, output item_value, input ready);
  modport sink   (input valid, input opcode, input item_value, output ready);
endinterface

interface dqu_out_if;
  logic                          valid;
  logic                          ready;
  logic [dqu_pkg::ITEM_W-1:0]    result_value;
  logic [dqu_pkg::STATUS_W-1:0]  status;
  logic [dqu_pkg::COUNT_W-1:0]   entry_count;
  logic                          is_empty;

  modport source (output valid, output result_value, output status, output entry_count,
                  output is_empty, input ready);
  modport sink   (input valid, input result_value, input status, input entry_count,
                  input is_empty, output ready);
endinterface

[design/dqu_cell.sv]
// one storage cell of the deque chain, cell zero holds the front entry
module dqu_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dqu_pkg::cell_ctrl_t    ctrl_i,
  input  logic [DATA_WIDTH-1:0]  left_data_i,
  input  logic                   left_occ_i,
  input  logic [DATA_WIDTH-1:0]  right_data_i,
  input  logic                   right_occ_i,
  input  logic [DATA_WIDTH-1:0]  push_data_i,
  output logic [DATA_WIDTH-1:0]  data_o,
  output logic                   occ_o,
  output logic                   is_back_o
);
  import dqu_pkg::*;

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic                  occ_r, occ_nxt;

  always_comb begin
    data_nxt = data_r;
    occ_nxt  = occ_r;
    case (ctrl_i.op)
      CELL_SHIFT_IN_FRONT: begin
        data_nxt = left_data_i;
        occ_nxt  = left_occ_i;
      end
      CELL_SHIFT_OUT_FRONT: begin
        data_nxt = right_data_i;
        occ_nxt  = right_occ_i;
      end
      CELL_FILL_BACK: begin
        if (!occ_r && left_occ_i) begin
          data_nxt = push_data_i;
          occ_nxt  = 1'b1;
        end
      end
      CELL_DROP_BACK: begin
        if (occ_r && !right_occ_i) begin
          occ_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o    = data_r;
  assign occ_o     = occ_r;
  assign is_back_o = occ_r && !right_occ_i;
endmodule

[design/double_ended_queue_unit.sv]
// top level of the double-ended queue unit
`include "double_ended_queue_unit_assert.svh"

// Double-ended queue of CAPACITY words held in a row of cells, front entry in
// cell zero. Push front and pop front shift the whole row by one cell; push
// back and pop back touch only the cell at the occupied edge. Each request
// yields one registered result in the cycle after it is taken, and a new
// request is taken in every cycle in which the result register is empty or is
// drained in that cycle, so the unit sustains one operation per cycle. The
// back word is picked from the row by an OR over all cells, which sets the
// longest path at large CAPACITY. The store needs no clearing after reset.
module double_ended_queue_unit #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  dqu_in_if.sink    in_ch,
  dqu_out_if.source out_ch
);
  import dqu_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]   cell_occ;
  logic [CAPACITY-1:0]   cell_back;
  logic [DATA_WIDTH-1:0] push_word;
  logic [DATA_WIDTH-1:0] back_word;
  logic [DATA_WIDTH-1:0] front_word;
  cell_ctrl_t            ctrl;
  cell_op_t              op_sel;

  logic                  in_fire;
  logic                  full, empty;
  logic [CW-1:0]         count_r, count_nxt;
  logic [DATA_WIDTH-1:0] result_sel;
  logic [STATUS_W-1:0]   status_sel;

  logic                  out_valid_r;
  logic [ITEM_W-1:0]     out_value_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [COUNT_W-1:0]    out_count_r;
  logic                  out_empty_r;

  logic                  empty_pop;
  logic                  full_push;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign push_word   = DATA_WIDTH'(in_ch.item_value);
  assign full        = (count_r == CW'(CAPACITY));
  assign empty       = (count_r == '0);
  assign front_word  = cell_data[0];

  always_comb begin
    back_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_word = back_word | (cell_back[i] ? cell_data[i] : '0);
    end
  end

  // request decode
  always_comb begin
    op_sel     = CELL_HOLD;
    count_nxt  = count_r;
    result_sel = '0;
    status_sel = ST_OK;
    case (in_ch.opcode)
      OP_PUSH_BACK: begin
        if (full) begin
          status_sel = ST_FULL;
        end else begin
          op_sel    = CELL_FILL_BACK;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          status_sel = ST_FULL;
        end else begin
          op_sel    = CELL_SHIFT_IN_FRONT;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_sel = ST_EMPTY;
        end else begin
          op_sel     = CELL_DROP_BACK;
          result_sel = back_word;
          count_nxt  = count_r - CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_sel = ST_EMPTY;
        end else begin
          op_sel     = CELL_SHIFT_OUT_FRONT;
          result_sel = front_word;
          count_nxt  = count_r - CW'(1);
        end
      end
      OP_PEEK_BACK: begin
        if (empty) begin
          status_sel = ST_EMPTY;
        end else begin
          result_sel = back_word;
        end
      end
      OP_PEEK_FRONT: begin
        if (empty) begin
          status_sel = ST_EMPTY;
        end else begin
          result_sel = front_word;
        end
      end
      default: begin
      end
    endcase
  end

  assign ctrl.op = in_fire ? op_sel : CELL_HOLD;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data, right_data;
      logic                  left_occ, right_occ;
      if (g == 0) begin : g_first
        assign left_data = push_word;
        assign left_occ  = 1'b1;
      end else begin : g_mid
        assign left_data = cell_data[g-1];
        assign left_occ  = cell_occ[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_data = '0;
        assign right_occ  = 1'b0;
      end else begin : g_inner
        assign right_data = cell_data[g+1];
        assign right_occ  = cell_occ[g+1];
      end
      dqu_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl_i       (ctrl),
        .left_data_i  (left_data),
        .left_occ_i   (left_occ),
        .right_data_i (right_data),
        .right_occ_i  (right_occ),
        .push_data_i  (push_word),
        .data_o       (cell_data[g]),
        .occ_o        (cell_occ[g]),
        .is_back_o    (cell_back[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_value_r  <= ITEM_W'(result_sel);
      out_status_r <= status_sel;
      out_count_r  <= COUNT_W'(count_nxt);
      out_empty_r  <= (count_nxt == '0);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.entry_count  = out_count_r;
  assign out_ch.is_empty     = out_empty_r;

  assign empty_pop = in_fire && empty &&
                     (in_ch.opcode == OP_POP_FRONT || in_ch.opcode == OP_POP_BACK);
  assign full_push = in_fire && full &&
                     (in_ch.opcode == OP_PUSH_BACK || in_ch.opcode == OP_PUSH_FRONT);

  `DQU_ASSERT_ALWAYS(a_occ_matches_count, clk, rst_n, $countones(cell_occ) == int'(count_r))
  `DQU_ASSERT_ALWAYS(a_count_in_range, clk, rst_n, count_r <= CW'(CAPACITY))
  `DQU_ASSERT_NEXT(a_pop_empty_status, clk, rst_n, empty_pop, out_status_r == ST_EMPTY && empty)
  `DQU_ASSERT_NEXT(a_push_full_holds, clk, rst_n, full_push, out_status_r == ST_FULL && full)
endmodule

[verif/double_ended_queue_unit_tb.sv]
// self-checking testbench of the double-ended queue unit with a ring predictor
module double_ended_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dqu_pkg::*;

  localparam int DEQUE_DEPTH = 16;
  localparam int SLOT_W = $clog2(DEQUE_DEPTH);
  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int SHOWN_MISMATCHES = 10;

  localparam logic [OPCODE_W-1:0] OP_UNUSED_A = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_B = 3'd7;

  typedef struct packed {
    logic [ITEM_W-1:0]   result_value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
    logic                is_empty;
  } deque_result_t;

  typedef struct packed {
    bit            typed;
    deque_result_t res;
  } row_tag_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [ITEM_W-1:0]   word;
    bit                  typed;
    deque_result_t       res;
  } stim_row_t;

  logic clk;
  logic rst_n;

  dqu_in_if  in_ch();
  dqu_out_if out_ch();

  double_ended_queue_unit u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // empty cases, unused opcodes, two pushes, fill to full, rejected push, then read both ends
  stim_row_t directed_rows [0:26] = '{
    '{OP_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h0, ST_EMPTY, 5'd0, 1'b1}},
    '{OP_POP_BACK,   32'h0000_0000, 1'b1, '{32'h0, ST_EMPTY, 5'd0, 1'b1}},
    '{OP_PEEK_FRONT, 32'hFFFF_FFFF, 1'b1, '{32'h0, ST_EMPTY, 5'd0, 1'b1}},
    '{OP_PEEK_BACK,  32'hFFFF_FFFF, 1'b1, '{32'h0, ST_EMPTY, 5'd0, 1'b1}},
    '{OP_UNUSED_A,   32'hFFFF_FFFF, 1'b1, '{32'h0, ST_OK, 5'd0, 1'b1}},
    '{OP_UNUSED_B,   32'h0000_0000, 1'b1, '{32'h0, ST_OK, 5'd0, 1'b1}},
    '{OP_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, '{32'h0, ST_OK, 5'd1, 1'b0}},
    '{OP_PUSH_FRONT, 32'h0000_0000, 1'b1, '{32'h0, ST_OK, 5'd2, 1'b0}},
    '{OP_PUSH_BACK,  32'h8000_0000, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'h0000_0001, 1'b0, '0},
    '{OP_PUSH_BACK,  32'hAAAA_AAAA, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'h5555_5555, 1'b0, '0},
    '{OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'hFFFF_FFFE, 1'b0, '0},
    '{OP_PUSH_BACK,  32'h0000_FFFF, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'hFFFF_0000, 1'b0, '0},
    '{OP_PUSH_BACK,  32'h1234_5678, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'h89AB_CDEF, 1'b0, '0},
    '{OP_PUSH_BACK,  32'h0000_0000, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_PUSH_BACK,  32'h0F0F_0F0F, 1'b0, '0},
    '{OP_PUSH_FRONT, 32'hF0F0_F0F0, 1'b0, '0},
    '{OP_PUSH_BACK,  32'hDEAD_BEEF, 1'b1, '{32'h0, ST_FULL, 5'd16, 1'b0}},
    '{OP_PEEK_FRONT, 32'h0000_0000, 1'b0, '0},
    '{OP_PEEK_BACK,  32'h0000_0000, 1'b0, '0},
    '{OP_POP_BACK,   32'h0000_0000, 1'b0, '0},
    '{OP_POP_FRONT,  32'h0000_0000, 1'b0, '0}
  };

  logic [ITEM_W-1:0]  ring_words [DEQUE_DEPTH];
  logic [SLOT_W-1:0]  head_slot;
  logic [COUNT_W-1:0] fill_level;

  row_tag_t      row_tags[$];
  deque_result_t awaited_results[$];
  int            err_count;
  int            cycle_cnt;
  int            burst_left;

  initial clk = 1'b0;
  always #5ns clk = ~clk;

  function automatic deque_result_t predict_deque(logic [OPCODE_W-1:0] op,
                                                  logic [ITEM_W-1:0] word);
    deque_result_t r;
    logic [SLOT_W-1:0] slot;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (fill_level == COUNT_W'(DEQUE_DEPTH)) begin
          r.status = ST_FULL;
        end else begin
          if (op == OP_PUSH_BACK) begin
            slot = head_slot + fill_level[SLOT_W-1:0];
          end else begin
            head_slot = head_slot - SLOT_W'(1);
            slot = head_slot;
          end
          ring_words[slot] = word;
          fill_level = fill_level + COUNT_W'(1);
        end
      end
      OP_POP_BACK, OP_POP_FRONT, OP_PEEK_BACK, OP_PEEK_FRONT: begin
        if (fill_level == '0) begin
          r.status = ST_EMPTY;
        end else begin
          if (op == OP_POP_BACK || op == OP_PEEK_BACK) begin
            slot = head_slot + fill_level[SLOT_W-1:0] - SLOT_W'(1);
          end else begin
            slot = head_slot;
          end
          r.result_value = ring_words[slot];
          if (op == OP_POP_FRONT) begin
            head_slot = head_slot + SLOT_W'(1);
          end
          if (op == OP_POP_BACK || op == OP_POP_FRONT) begin
            fill_level = fill_level - COUNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    r.entry_count = fill_level;
    r.is_empty = (fill_level == '0);
    return r;
  endfunction

  function automatic void report_mismatch(string why, deque_result_t want,
                                          deque_result_t got);
    err_count++;
    if (err_count <= SHOWN_MISMATCHES) begin
      $write("%0t %s: exp value %h status %0d count %0d empty %0d, ",
             $realtime, why, want.result_value, want.status, want.entry_count,
             want.is_empty);
      $display("got value %h status %0d count %0d empty %0d",
               got.result_value, got.status, got.entry_count, got.is_empty);
    end
  endfunction

  // sender: bursts of random length separated by random gaps
  task automatic issue_request(logic [OPCODE_W-1:0] op, logic [ITEM_W-1:0] word,
                               bit typed, deque_result_t res);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.item_value <= word;
    row_tags.push_back('{typed, res});
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // monitor, scoreboard, receiver stall pattern and watchdog
  always @(posedge clk) begin
    row_tag_t      tag;
    deque_result_t want;
    deque_result_t got;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      if (rst_n) begin
        if (in_ch.valid && in_ch.ready) begin
          tag = row_tags.pop_front();
          want = predict_deque(in_ch.opcode, in_ch.item_value);
          if (tag.typed) begin
            want = tag.res;
          end
          awaited_results.push_back(want);
        end
        if (out_ch.valid && out_ch.ready) begin
          got = '{out_ch.result_value, out_ch.status, out_ch.entry_count, out_ch.is_empty};
          if (awaited_results.size() == 0) begin
            report_mismatch("unexpected result", '0, got);
          end else begin
            want = awaited_results.pop_front();
            if (got.result_value !== want.result_value || got.status !== want.status ||
                got.entry_count !== want.entry_count || got.is_empty !== want.is_empty) begin
              report_mismatch("result mismatch", want, got);
            end
          end
        end
      end
      case ((cycle_cnt / 128) % 4)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 99) < 70);
        2: out_ch.ready <= (cycle_cnt % 4 != 3);
        default: out_ch.ready <= ($urandom_range(0, 99) < 30);
      endcase
    end
  end

  initial begin
    int useful;
    int regime;
    int push_pct;
    logic [OPCODE_W-1:0] op;
    logic [ITEM_W-1:0] word;
    err_count = 0;
    cycle_cnt = 0;
    burst_left = 0;
    head_slot = '0;
    fill_level = '0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_PUSH_BACK;
    in_ch.item_value = '0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      issue_request(directed_rows[i].op, directed_rows[i].word, directed_rows[i].typed,
                    directed_rows[i].res);
    end
    wait_drained();

    useful = 0;
    regime = 2;
    while (useful < RANDOM_ITEMS) begin
      if (useful % 40 == 0) begin
        regime = $urandom_range(0, 2);
      end
      push_pct = regime == 0 ? 70 : (regime == 1 ? 25 : 50);
      case ($urandom_range(0, 7))
        0: word = '0;
        1: word = '1;
        2: word = ITEM_W'(1) << $urandom_range(0, ITEM_W - 1);
        default: word = $urandom;
      endcase
      if ($urandom_range(0, 99) < 3) begin
        op = $urandom_range(0, 1) ? OP_UNUSED_A : OP_UNUSED_B;
      end else begin
        useful++;
        if ($urandom_range(0, 99) < push_pct) begin
          op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end else begin
          case ($urandom_range(0, 5))
            0, 1: op = OP_POP_BACK;
            2, 3: op = OP_POP_FRONT;
            4: op = OP_PEEK_BACK;
            default: op = OP_PEEK_FRONT;
          endcase
        end
      end
      issue_request(op, word, 1'b0, '0);
      if (useful == RANDOM_ITEMS / 2 && op != OP_UNUSED_A && op != OP_UNUSED_B) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
